// File: sv/vsma_pkg.sv
// ----------------------------------------------------------------------------
// vsma_pkg
// Shared types and constants for the valid sample moving average block.
// ----------------------------------------------------------------------------
package vsma_pkg;

    // ring geometry
    localparam int WINDOW   = 8;
    localparam int SLOT_W   = 3;   // index into the ring
    localparam int TOTAL_W  = 4;   // holds 0 .. WINDOW

    // data widths
    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 20;  // running sum of up to WINDOW samples
    localparam int DIV_CNT_W = 5;  // counts SUM_W divider steps

    // absolute zero in hundredths of a degree, also the empty-ring result
    localparam logic signed [SAMPLE_W-1:0] INVALID_MARK = -16'sd27315;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_FINISH
    } vsma_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// File: sv/vsma_ring.sv
// ----------------------------------------------------------------------------
// vsma_ring
// Sample ring with per-slot valid flags, running sum and valid count.
// ----------------------------------------------------------------------------
module vsma_ring
    import vsma_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       wr_en,
    input  logic signed [SAMPLE_W-1:0] wr_sample,
    output logic signed [SUM_W-1:0]    valid_sum,
    output logic [TOTAL_W-1:0]         valid_total
);

    logic signed [SAMPLE_W-1:0] data_reg [WINDOW];
    logic [WINDOW-1:0]          vld_reg;
    logic [SLOT_W-1:0]          slot_reg;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic [TOTAL_W-1:0]         total_reg, total_next;
    logic                       old_v, new_v;
    logic signed [SAMPLE_W-1:0] old_data;
    logic signed [SUM_W-1:0]    old_term, new_term;

    // a flag marks a slot holding a sample above the marker; a cleared flag
    // reads as the marker, so the data itself needs no reset
    assign old_v    = vld_reg[slot_reg];
    assign old_data = data_reg[slot_reg];
    assign new_v    = wr_sample > INVALID_MARK;

    always_comb begin
        old_term = old_v ? {{(SUM_W-SAMPLE_W){old_data[SAMPLE_W-1]}}, old_data}
                         : '0;
        new_term = new_v ? {{(SUM_W-SAMPLE_W){wr_sample[SAMPLE_W-1]}}, wr_sample}
                         : '0;
        sum_next   = sum_reg - old_term + new_term;
        total_next = total_reg - TOTAL_W'(old_v) + TOTAL_W'(new_v);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg   <= '0;
            slot_reg  <= '0;
            sum_reg   <= '0;
            total_reg <= '0;
        end else if (wr_en) begin
            vld_reg[slot_reg] <= new_v;
            sum_reg           <= sum_next;
            total_reg         <= total_next;
            if (slot_reg == SLOT_W'(WINDOW - 1)) begin
                slot_reg <= '0;
            end else begin
                slot_reg <= slot_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            data_reg[slot_reg] <= wr_sample;
        end
    end

    assign valid_sum   = sum_reg;
    assign valid_total = total_reg;

    a_total_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= TOTAL_W'(WINDOW))
        else $error("valid count beyond window");

    a_empty_sum_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (total_reg == '0) |-> (sum_reg == '0))
        else $error("nonzero sum with no valid samples");

endmodule

// File: sv/vsma_divider.sv
// ----------------------------------------------------------------------------
// vsma_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vsma_divider
    import vsma_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [SUM_W-1:0]    dividend,
    input  logic [TOTAL_W-1:0]  divisor,
    output logic [SUM_W-1:0]    quotient,
    output div_status_t         status
);

    logic                 busy_reg, done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0]     quo_reg, quo_next;
    logic [TOTAL_W-1:0]   rem_reg, rem_next;
    logic [TOTAL_W-1:0]   dvs_reg;
    logic [TOTAL_W:0]     shifted;

    // shift in the next dividend bit, subtract when it fits
    always_comb begin
        shifted = {rem_reg, quo_reg[SUM_W-1]};
        if (shifted >= {1'b0, dvs_reg}) begin
            rem_next = TOTAL_W'(shifted - {1'b0, dvs_reg});
            quo_next = {quo_reg[SUM_W-2:0], 1'b1};
        end else begin
            rem_next = shifted[TOTAL_W-1:0];
            quo_next = {quo_reg[SUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(SUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// File: sv/valid_sample_moving_average.sv
// ----------------------------------------------------------------------------
// valid_sample_moving_average
// Moving average over a ring of temperature samples, skipping invalid ones.
// ----------------------------------------------------------------------------
//  channel   direction  ports                                  handshake
//  s_        in         s_sample_centi                         s_valid/s_ready
//  m_        out        m_average_centi, m_valid_count         m_valid/m_ready
//
//  After acceptance the result reaches the output register in these steps:
//  divider start, divider steps (one per sum bit), taking the quotient, load.
//  Input is ready again in the cycle after the load; an empty ring skips the
//  divider and goes straight from the start state to the load.
//  Synchronous active-low reset empties the ring; no clearing pass is needed.
//  A result waiting on m_ready stalls the next result only at its final load, and holds input ready low meanwhile.
// ----------------------------------------------------------------------------
module valid_sample_moving_average
    import vsma_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample_centi,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] m_average_centi,
    output logic [TOTAL_W-1:0]         m_valid_count
);

    vsma_state_t                state_reg, state_next;
    logic signed [SUM_W-1:0]    valid_sum;
    logic [TOTAL_W-1:0]         valid_total;
    logic [SUM_W-1:0]           quotient;
    div_status_t                div_status;
    logic                       div_start;
    logic                       accept;
    logic                       out_load;
    logic                       neg_reg;
    logic [SUM_W-1:0]           magnitude;
    logic signed [SAMPLE_W-1:0] avg_reg;
    logic [SUM_W-1:0]           signed_quo;
    logic                       m_valid_reg;
    logic signed [SAMPLE_W-1:0] m_avg_reg;
    logic [TOTAL_W-1:0]         m_cnt_reg;

    assign accept = s_valid && s_ready;

    vsma_ring u_ring (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .wr_en       (accept),
        .wr_sample   (s_sample_centi),
        .valid_sum   (valid_sum),
        .valid_total (valid_total)
    );

    assign magnitude = valid_sum[SUM_W-1] ? SUM_W'(-valid_sum) : SUM_W'(valid_sum);

    vsma_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (magnitude),
        .divisor  (valid_total),
        .quotient (quotient),
        .status   (div_status)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) state_next = ST_START;
            end
            ST_START: begin
                if (valid_total == '0) state_next = ST_FINISH;
                else                   state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (div_status.done) state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_ready   = 1'b1;
            ST_START:  div_start = (valid_total != '0);
            ST_WAIT:   ;
            ST_FINISH: out_load  = !m_valid_reg || m_ready;
            default:   ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign signed_quo = neg_reg ? SUM_W'(-quotient) : quotient;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_START) begin
            neg_reg <= valid_sum[SUM_W-1];
            if (valid_total == '0) begin
                avg_reg <= INVALID_MARK;
            end
        end
        if (state_reg == ST_WAIT && div_status.done) begin
            avg_reg <= signed_quo[SAMPLE_W-1:0];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_avg_reg <= avg_reg;
            m_cnt_reg <= valid_total;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_average_centi = m_avg_reg;
    assign m_valid_count   = m_cnt_reg;

    a_idle_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !div_status.busy)
        else $error("divider busy while sequencer idle");

    a_empty_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_cnt_reg == '0) |-> (m_avg_reg == INVALID_MARK))
        else $error("empty ring must report the marker");

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_status.done |-> (state_reg == ST_WAIT))
        else $error("divider finished outside the wait state");

endmodule
